// ===== hw/rtl/i2cra_pkg.sv =====
package i2cra_pkg;

    localparam int MAX_BURST   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    // operation codes of a command
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_PROBE = 2'd2;

    // item kinds
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // classified request handed from the front end to the engine
    typedef struct packed {
        logic       is_tick;
        logic       cmd_ok;
        logic [1:0] op;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_value;
        logic [4:0] count;
        logic       sda_in;
    } t_req;

endpackage

// ===== hw/rtl/i2c_register_access_master_unit.sv =====
// the engine writes a request's result to the output register as it takes it from the queue
// throughput: one request per cycle unless the output stalls; the engine steps its line
// state machine once per request. A two-entry request queue parts the input handshake from
// the engine and its output register. Reset (synchronous, active low) empties the queue and
// output, returns the engine to idle and releases both lines
module i2c_register_access_master_unit #(
    parameter int MAX_BURST = i2cra_pkg::MAX_BURST
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // op[1:0], dev_addr[8:2], reg_addr[16:9], write_value[24:17], count[29:25],
    // sda_in[30], zero[31]
    input  logic [i2cra_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // kind[0]
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // scl_low[0], sda_low[1], read_data[9:2], done_res[10], nack_error[11],
    // busy_res[12], zero[15:13]
    output logic [i2cra_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // data_valid[0]
    output logic                                o_m_axis_tuser,
    // last_byte
    output logic                                o_m_axis_tlast
);

    i2cra_pkg::t_req w_req;
    logic            w_req_valid;
    logic            w_req_pop;

    i2cra_front #(
        .MAX_BURST   (MAX_BURST)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser),
        .i_data      (i_s_axis_tdata),
        .o_req       (w_req),
        .o_req_valid (w_req_valid),
        .i_req_pop   (w_req_pop)
    );

    i2cra_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_req_valid (w_req_valid),
        .o_req_pop   (w_req_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata),
        .o_user      (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

endmodule

// ===== hw/rtl/i2cra_front.sv =====
module i2cra_front #(
    parameter int MAX_BURST = i2cra_pkg::MAX_BURST
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_kind,
    input  logic [i2cra_pkg::IN_TDATA_W-1:0]    i_data,
    output i2cra_pkg::t_req                     o_req,
    output logic                                o_req_valid,
    input  logic                                i_req_pop
);

    i2cra_pkg::t_req                         r_mem [i2cra_pkg::QUEUE_DEPTH];
    logic [i2cra_pkg::QPTR_W-1:0]            r_wr_ptr;
    logic [i2cra_pkg::QPTR_W-1:0]            r_rd_ptr;
    logic [i2cra_pkg::QCNT_W-1:0]            r_count;
    i2cra_pkg::t_req                         w_req;
    logic [4:0]                              w_cnt_raw;
    logic [4:0]                              w_cnt_min;
    logic                                    w_push;
    logic                                    w_pop;

    // classify the request and clamp the burst length between one and MAX_BURST
    always_comb begin
        w_cnt_raw         = i_data[29:25];
        w_cnt_min         = (w_cnt_raw == 5'd0) ? 5'd1 : w_cnt_raw;
        w_req.is_tick     = (i_kind == i2cra_pkg::KIND_TICK);
        w_req.op          = i_data[1:0];
        w_req.cmd_ok      = (i_kind == i2cra_pkg::KIND_CMD) &&
                            (i_data[1:0] == i2cra_pkg::OP_WRITE ||
                             i_data[1:0] == i2cra_pkg::OP_READ ||
                             i_data[1:0] == i2cra_pkg::OP_PROBE);
        w_req.dev_addr    = i_data[8:2];
        w_req.reg_addr    = i_data[16:9];
        w_req.write_value = i_data[24:17];
        w_req.count       = (int'(w_cnt_min) > MAX_BURST) ? 5'(MAX_BURST) : w_cnt_min;
        w_req.sda_in      = i_data[30];
    end

    assign o_ready     = (int'(r_count) < i2cra_pkg::QUEUE_DEPTH);
    assign w_push      = i_valid && o_ready;
    assign o_req_valid = (r_count != '0);
    assign w_pop       = i_req_pop && o_req_valid;
    assign o_req       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == i2cra_pkg::QUEUE_DEPTH - 1) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == i2cra_pkg::QUEUE_DEPTH - 1) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + i2cra_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - i2cra_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/i2cra_engine.sv =====
module i2cra_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  i2cra_pkg::t_req                     i_req,
    input  logic                                i_req_valid,
    output logic                                o_req_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [i2cra_pkg::OUT_TDATA_W-1:0]   o_data,
    output logic                                o_user,
    output logic                                o_last
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_START    = 4'd1,
        ST_RSTART   = 4'd2,
        ST_ADDRW    = 4'd3,
        ST_REG      = 4'd4,
        ST_VAL      = 4'd5,
        ST_ADDRR    = 4'd6,
        ST_READ     = 4'd7,
        ST_STOP     = 4'd8,
        ST_STOPNACK = 4'd9
    } t_stage;

    t_stage     r_stage, n_stage;
    logic [4:0] r_phase, n_phase;
    logic [7:0] r_shift, n_shift;
    logic [4:0] r_left,  n_left;
    logic [1:0] r_op,    n_op;
    logic [6:0] r_dev,   n_dev;
    logic [7:0] r_reg,   n_reg;
    logic [7:0] r_val,   n_val;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;

    logic       r_out_valid;
    logic [7:0] r_rdata, n_rdata;
    logic       r_dvalid, n_dvalid;
    logic       r_last,  n_last;
    logic       r_done,  n_done;
    logic       r_err,   n_err;
    logic       r_busy;

    logic       w_pop;
    logic [7:0] w_shift_in;
    logic [4:0] w_left_dec;

    assign w_pop     = i_req_valid && (!r_out_valid || i_ready);
    assign o_req_pop = w_pop;

    always_comb begin
        n_stage    = r_stage;
        n_phase    = r_phase;
        n_shift    = r_shift;
        n_left     = r_left;
        n_op       = r_op;
        n_dev      = r_dev;
        n_reg      = r_reg;
        n_val      = r_val;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_rdata    = 8'd0;
        n_dvalid   = 1'b0;
        n_last     = 1'b0;
        n_done     = 1'b0;
        n_err      = 1'b0;
        w_shift_in = {r_shift[6:0], i_req.sda_in};
        w_left_dec = (r_left != 5'd0) ? r_left - 5'd1 : r_left;

        if (!i_req.is_tick) begin
            if (r_stage == ST_IDLE && i_req.cmd_ok) begin
                n_op    = i_req.op;
                n_dev   = i_req.dev_addr;
                n_reg   = i_req.reg_addr;
                n_val   = i_req.write_value;
                n_left  = i_req.count;
                n_stage = ST_START;
                n_phase = 5'd1;
                n_scl   = 1'b0;
                n_sda   = 1'b0;
            end
        end else begin
            case (r_stage)
                ST_START, ST_RSTART: begin
                    if (r_phase == 5'd0) begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_phase = 5'd1;
                    end else if (r_phase == 5'd1) begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b1;
                        n_phase = 5'd2;
                    end else begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_shift = {r_dev, (r_stage == ST_RSTART)};
                        n_stage = (r_stage == ST_START) ? ST_ADDRW : ST_ADDRR;
                        n_phase = 5'd0;
                    end
                end
                ST_ADDRW, ST_REG, ST_VAL, ST_ADDRR: begin
                    if (r_phase < 5'd16) begin
                        n_scl   = ~r_phase[0];
                        n_sda   = ~r_shift[3'd7 - r_phase[3:1]];
                        n_phase = r_phase + 5'd1;
                    end else if (r_phase == 5'd16) begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b0;
                        n_phase = 5'd17;
                    end else if (r_phase == 5'd17) begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_phase = 5'd18;
                    end else begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b0;
                        n_phase = 5'd0;
                        if (i_req.sda_in) begin
                            n_stage = ST_STOPNACK;
                        end else begin
                            // next byte after an acknowledged one
                            case (r_stage)
                                ST_ADDRW: begin
                                    if (r_op == i2cra_pkg::OP_PROBE) begin
                                        n_stage = ST_STOP;
                                    end else begin
                                        n_stage = ST_REG;
                                        n_shift = r_reg;
                                    end
                                end
                                ST_REG: begin
                                    if (r_op == i2cra_pkg::OP_WRITE) begin
                                        n_stage = ST_VAL;
                                        n_shift = r_val;
                                    end else begin
                                        n_stage = ST_RSTART;
                                    end
                                end
                                ST_ADDRR: begin
                                    n_stage = ST_READ;
                                    n_shift = 8'd0;
                                end
                                default: n_stage = ST_STOP;
                            endcase
                        end
                    end
                end
                ST_READ: begin
                    // sample on the tick after each high phase
                    if (r_phase >= 5'd2 && r_phase <= 5'd16 && !r_phase[0]) begin
                        n_shift = w_shift_in;
                    end
                    if (r_phase < 5'd16) begin
                        n_scl   = ~r_phase[0];
                        n_sda   = 1'b0;
                        n_phase = r_phase + 5'd1;
                    end else if (r_phase == 5'd16) begin
                        n_dvalid = 1'b1;
                        n_rdata  = w_shift_in;
                        n_last   = (r_left <= 5'd1);
                        n_scl    = 1'b1;
                        n_sda    = (r_left > 5'd1);
                        n_phase  = 5'd17;
                    end else if (r_phase == 5'd17) begin
                        n_scl   = 1'b0;
                        n_phase = 5'd18;
                    end else begin
                        n_scl   = 1'b1;
                        n_left  = w_left_dec;
                        n_phase = 5'd0;
                        n_shift = 8'd0;
                        if (w_left_dec == 5'd0) begin
                            n_stage = ST_STOP;
                        end
                    end
                end
                ST_STOP, ST_STOPNACK: begin
                    if (r_phase == 5'd0) begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_phase = 5'd1;
                    end else if (r_phase == 5'd1) begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b1;
                        n_phase = 5'd2;
                    end else begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_done  = 1'b1;
                        n_err   = (r_stage == ST_STOPNACK);
                        n_stage = ST_IDLE;
                        n_phase = 5'd0;
                    end
                end
                default: begin
                    n_stage = ST_IDLE;
                    n_phase = 5'd0;
                    n_scl   = 1'b0;
                    n_sda   = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_IDLE;
            r_phase     <= 5'd0;
            r_shift     <= 8'd0;
            r_left      <= 5'd0;
            r_op        <= 2'd0;
            r_dev       <= 7'd0;
            r_reg       <= 8'd0;
            r_val       <= 8'd0;
            r_scl       <= 1'b0;
            r_sda       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_pop) begin
            r_stage     <= n_stage;
            r_phase     <= n_phase;
            r_shift     <= n_shift;
            r_left      <= n_left;
            r_op        <= n_op;
            r_dev       <= n_dev;
            r_reg       <= n_reg;
            r_val       <= n_val;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_pop) begin
            r_rdata  <= n_rdata;
            r_dvalid <= n_dvalid;
            r_last   <= n_last;
            r_done   <= n_done;
            r_err    <= n_err;
            r_busy   <= (n_stage != ST_IDLE);
        end
    end

    assign o_valid = r_out_valid;
    assign o_user  = r_dvalid;
    assign o_last  = r_last;
    assign o_data  = {3'd0, r_busy, r_err, r_done, r_rdata, r_sda, r_scl};

    a_err_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_err |-> r_done)
        else $error("nack error reported without stop");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_done |-> !r_busy && r_stage == ST_IDLE)
        else $error("stop reported while still busy");

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage == ST_IDLE |-> !r_scl && !r_sda)
        else $error("lines driven while idle");

    a_byte_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_dvalid |-> !r_done && r_stage == ST_READ)
        else $error("read byte outside a read burst");

endmodule

// ===== tb/tb_i2c_register_access_master_unit.sv =====
`timescale 1ns / 1ps

module tb_i2c_register_access_master_unit;
    import i2cra_pkg::*;

    localparam int ITEMS       = 1850;
    localparam int CYCLE_LIMIT = 400000;

    // an operation code the block has to ignore
    localparam logic [1:0] OP_BAD = 2'd3;

    // how the target answers on the line while a transaction runs
    localparam int RUN_NONE       = 0;
    localparam int RUN_ACK        = 1;
    localparam int RUN_NACK_FIRST = 2;
    localparam int RUN_NACK_LAST  = 3;
    localparam int RUN_ONES       = 4;
    localparam int RUN_ZEROS      = 5;
    localparam int RUN_RANDOM     = 6;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_RSTART, S_ADDRW, S_REG, S_VAL, S_ADDRR, S_READ, S_STOP, S_STOPNACK
    } line_stage_e;

    typedef struct packed {
        logic       kind;
        logic [1:0] op;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_value;
        logic [4:0] count;
        logic       sda;
    } bus_req_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic [7:0] rdata;
        logic       data_valid;
        logic       last_byte;
        logic       done;
        logic       nack;
        logic       busy;
    } bus_res_t;

    typedef struct packed {
        bus_req_t req;
        logic     typed;
        logic     busy;
        int       run;
    } plan_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // line engine mirror
    line_stage_e stage_q = S_IDLE;
    logic [4:0]  phase_q = '0;
    logic [7:0]  shift_q = '0;
    logic [4:0]  left_q  = '0;
    logic [1:0]  op_q    = '0;
    logic [6:0]  dev_q   = '0;
    logic [7:0]  reg_q   = '0;
    logic [7:0]  val_q   = '0;
    logic        scl_q   = 1'b0;
    logic        sda_q   = 1'b0;

    bus_res_t expected_lines[$];
    int       n_items     = 0;
    int       burst_left  = 0;
    int       mismatches  = 0;
    int       cycles      = 0;
    int       stall_tick  = 0;
    int       stall_mode  = 0;

    i2c_register_access_master_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver stalls: ready follows one of four patterns, chosen anew at random as stall_tick counts up
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            2: i_m_axis_tready <= (stall_tick % 4 == 0);
            default: i_m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    function automatic bus_res_t step_bus(input bus_req_t r);
        bus_res_t o;
        logic     bit_out;
        o = '0;
        if (r.kind == KIND_CMD) begin
            if (stage_q == S_IDLE && r.op != OP_BAD) begin
                op_q  = r.op;
                dev_q = r.dev_addr;
                reg_q = r.reg_addr;
                val_q = r.write_value;
                if (r.count == 5'd0) left_q = 5'd1;
                else if (r.count > 5'(MAX_BURST)) left_q = 5'(MAX_BURST);
                else left_q = r.count;
                stage_q = S_START;
                phase_q = 5'd1;
                scl_q   = 1'b0;
                sda_q   = 1'b0;
            end
        end else begin
            case (stage_q)
                S_START, S_RSTART: begin
                    if (phase_q == 5'd0) begin
                        scl_q = 1'b0; sda_q = 1'b0; phase_q = 5'd1;
                    end else if (phase_q == 5'd1) begin
                        scl_q = 1'b0; sda_q = 1'b1; phase_q = 5'd2;
                    end else begin
                        scl_q   = 1'b1; sda_q = 1'b1;
                        shift_q = {dev_q, stage_q == S_RSTART};
                        stage_q = (stage_q == S_START) ? S_ADDRW : S_ADDRR;
                        phase_q = 5'd0;
                    end
                end
                S_ADDRW, S_REG, S_VAL, S_ADDRR: begin
                    if (phase_q < 5'd16) begin
                        bit_out = shift_q[3'd7 - phase_q[3:1]];
                        scl_q   = ~phase_q[0];
                        sda_q   = ~bit_out;
                        phase_q++;
                    end else if (phase_q == 5'd16) begin
                        scl_q = 1'b1; sda_q = 1'b0; phase_q = 5'd17;
                    end else if (phase_q == 5'd17) begin
                        scl_q = 1'b0; sda_q = 1'b0; phase_q = 5'd18;
                    end else begin
                        // ack slot sampled here
                        scl_q   = 1'b1; sda_q = 1'b0;
                        phase_q = 5'd0;
                        if (r.sda) begin
                            stage_q = S_STOPNACK;
                        end else begin
                            case (stage_q)
                                S_ADDRW: begin
                                    if (op_q == OP_PROBE) begin
                                        stage_q = S_STOP;
                                    end else begin
                                        stage_q = S_REG;
                                        shift_q = reg_q;
                                    end
                                end
                                S_REG: begin
                                    if (op_q == OP_WRITE) begin
                                        stage_q = S_VAL;
                                        shift_q = val_q;
                                    end else begin
                                        stage_q = S_RSTART;
                                    end
                                end
                                S_ADDRR: begin
                                    stage_q = S_READ;
                                    shift_q = '0;
                                end
                                default: stage_q = S_STOP;
                            endcase
                        end
                    end
                end
                S_READ: begin
                    if (phase_q >= 5'd2 && phase_q <= 5'd16 && !phase_q[0])
                        shift_q = {shift_q[6:0], r.sda};
                    if (phase_q < 5'd16) begin
                        scl_q = ~phase_q[0]; sda_q = 1'b0; phase_q++;
                    end else if (phase_q == 5'd16) begin
                        o.data_valid = 1'b1;
                        o.rdata      = shift_q;
                        o.last_byte  = (left_q <= 5'd1);
                        scl_q        = 1'b1;
                        sda_q        = ~o.last_byte;
                        phase_q      = 5'd17;
                    end else if (phase_q == 5'd17) begin
                        scl_q = 1'b0; phase_q = 5'd18;
                    end else begin
                        scl_q = 1'b1;
                        if (left_q != 5'd0) left_q--;
                        phase_q = 5'd0;
                        shift_q = '0;
                        if (left_q == 5'd0) stage_q = S_STOP;
                    end
                end
                S_STOP, S_STOPNACK: begin
                    if (phase_q == 5'd0) begin
                        scl_q = 1'b1; sda_q = 1'b1; phase_q = 5'd1;
                    end else if (phase_q == 5'd1) begin
                        scl_q = 1'b0; sda_q = 1'b1; phase_q = 5'd2;
                    end else begin
                        scl_q   = 1'b0; sda_q = 1'b0;
                        o.done  = 1'b1;
                        o.nack  = (stage_q == S_STOPNACK);
                        stage_q = S_IDLE;
                        phase_q = 5'd0;
                    end
                end
                default: begin
                    stage_q = S_IDLE; phase_q = 5'd0; scl_q = 1'b0; sda_q = 1'b0;
                end
            endcase
        end
        o.scl_low = scl_q;
        o.sda_low = sda_q;
        o.busy    = (stage_q != S_IDLE);
        return o;
    endfunction

    // sda level the target presents on the next tick
    function automatic logic tick_sda(input int mode);
        logic ack_slot;
        logic last_slot;
        logic level;
        ack_slot  = (stage_q inside {S_ADDRW, S_REG, S_VAL, S_ADDRR}) && phase_q == 5'd18;
        last_slot = (op_q == OP_WRITE && stage_q == S_VAL) ||
                    (op_q == OP_READ && stage_q == S_ADDRR) ||
                    (op_q == OP_PROBE && stage_q == S_ADDRW);
        if (ack_slot) begin
            case (mode)
                RUN_NACK_FIRST: level = (stage_q == S_ADDRW);
                RUN_NACK_LAST:  level = last_slot;
                RUN_RANDOM:     level = ($urandom_range(0, 11) == 0);
                default:        level = 1'b0;
            endcase
        end else if (mode == RUN_ONES) begin
            level = 1'b1;
        end else if (mode == RUN_ZEROS) begin
            level = 1'b0;
        end else begin
            level = 1'($urandom_range(0, 1));
        end
        return level;
    endfunction

    function automatic bus_req_t random_req();
        bus_req_t r;
        r.kind        = 1'($urandom);
        r.op          = 2'($urandom);
        r.dev_addr    = 7'($urandom);
        r.reg_addr    = 8'($urandom);
        r.write_value = 8'($urandom);
        r.count       = 5'($urandom);
        r.sda         = 1'($urandom);
        return r;
    endfunction

    function automatic plan_row_t plan_row(input logic kind, input logic [1:0] op,
                                           input logic [6:0] dev, input logic [7:0] ra,
                                           input logic [7:0] wv, input logic [4:0] cnt,
                                           input logic sda, input logic typed,
                                           input logic busy, input int run);
        plan_row_t p;
        p.req   = '{kind, op, dev, ra, wv, cnt, sda};
        p.typed = typed;
        p.busy  = busy;
        p.run   = run;
        return p;
    endfunction

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_req(input bus_req_t r, input bit counted, input logic typed,
                            input logic busy);
        bus_res_t res;
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                                     : $urandom_range(1, 20);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= r.kind;
        i_s_axis_tdata  <= {1'b0, r.sda, r.count, r.write_value, r.reg_addr, r.dev_addr, r.op};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        res = step_bus(r);
        if (typed) begin
            res      = '0;
            res.busy = busy;
        end
        expected_lines.push_back(res);
        if (counted) n_items++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic run_to_idle(input int mode);
        bus_req_t t;
        while (stage_q != S_IDLE) begin
            // stray command in the middle of a transaction
            if (mode == RUN_RANDOM && $urandom_range(0, 24) == 0) begin
                t      = random_req();
                t.kind = KIND_CMD;
                send_req(t, 1'b0, 1'b0, 1'b0);
            end
            t      = random_req();
            t.kind = KIND_TICK;
            t.sda  = tick_sda(mode);
            send_req(t, 1'b1, 1'b0, 1'b0);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        bus_res_t got;
        bus_res_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.scl_low    = o_m_axis_tdata[0];
            got.sda_low    = o_m_axis_tdata[1];
            got.rdata      = o_m_axis_tdata[9:2];
            got.done       = o_m_axis_tdata[10];
            got.nack       = o_m_axis_tdata[11];
            got.busy       = o_m_axis_tdata[12];
            got.data_valid = o_m_axis_tuser;
            got.last_byte  = o_m_axis_tlast;
            if (expected_lines.size() == 0) begin
                $error("unexpected result: tdata %h", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_lines.pop_front();
                compare_field("scl_low", want.scl_low, got.scl_low);
                compare_field("sda_low", want.sda_low, got.sda_low);
                compare_field("read_data", want.rdata, got.rdata);
                compare_field("data_valid", want.data_valid, got.data_valid);
                compare_field("last_byte", want.last_byte, got.last_byte);
                compare_field("done_res", want.done, got.done);
                compare_field("nack_error", want.nack, got.nack);
                compare_field("busy_res", want.busy, got.busy);
            end
        end
    end

    initial begin
        plan_row_t plan[$];
        bus_req_t  req;
        int        pick;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;

        // kind, op, dev, reg, value, count, sda, typed, busy, target behavior
        plan.push_back(plan_row(KIND_TICK, OP_WRITE, 7'h00, 8'h00, 8'h00, 5'd0, 1'b1,
                                1'b1, 1'b0, RUN_NONE));
        plan.push_back(plan_row(KIND_TICK, OP_PROBE, 7'h7f, 8'hff, 8'hff, 5'd31, 1'b0,
                                1'b1, 1'b0, RUN_NONE));
        plan.push_back(plan_row(KIND_CMD, OP_BAD, 7'h7f, 8'hff, 8'hff, 5'd31, 1'b1,
                                1'b1, 1'b0, RUN_NONE));
        plan.push_back(plan_row(KIND_CMD, OP_WRITE, 7'h7f, 8'hff, 8'hff, 5'd0, 1'b0,
                                1'b1, 1'b1, RUN_ACK));
        plan.push_back(plan_row(KIND_CMD, OP_WRITE, 7'h00, 8'h00, 8'h00, 5'd0, 1'b0,
                                1'b1, 1'b1, RUN_NONE));
        // command while busy is dropped
        plan.push_back(plan_row(KIND_CMD, OP_PROBE, 7'h55, 8'h12, 8'h34, 5'd3, 1'b0,
                                1'b1, 1'b1, RUN_ACK));
        plan.push_back(plan_row(KIND_CMD, OP_PROBE, 7'h55, 8'h00, 8'h00, 5'd1, 1'b0,
                                1'b1, 1'b1, RUN_ACK));
        plan.push_back(plan_row(KIND_CMD, OP_PROBE, 7'h2a, 8'h00, 8'h00, 5'd1, 1'b0,
                                1'b0, 1'b0, RUN_NACK_FIRST));
        plan.push_back(plan_row(KIND_CMD, OP_READ, 7'h68, 8'h3b, 8'h00, 5'd0, 1'b0,
                                1'b0, 1'b0, RUN_ACK));
        plan.push_back(plan_row(KIND_CMD, OP_READ, 7'h68, 8'h00, 8'h00, 5'd31, 1'b0,
                                1'b0, 1'b0, RUN_ONES));
        plan.push_back(plan_row(KIND_CMD, OP_READ, 7'h11, 8'hff, 8'h00, 5'd16, 1'b0,
                                1'b0, 1'b0, RUN_ZEROS));
        plan.push_back(plan_row(KIND_CMD, OP_WRITE, 7'h5a, 8'ha5, 8'h3c, 5'd2, 1'b0,
                                1'b0, 1'b0, RUN_NACK_LAST));
        plan.push_back(plan_row(KIND_CMD, OP_WRITE, 7'h2b, 8'h0f, 8'hf0, 5'd1, 1'b0,
                                1'b0, 1'b0, RUN_NACK_FIRST));
        plan.push_back(plan_row(KIND_CMD, OP_READ, 7'h3c, 8'h81, 8'h00, 5'd2, 1'b0,
                                1'b0, 1'b0, RUN_NACK_FIRST));
        plan.push_back(plan_row(KIND_CMD, OP_READ, 7'h40, 8'h7e, 8'h00, 5'd3, 1'b0,
                                1'b0, 1'b0, RUN_NACK_LAST));
        plan.push_back(plan_row(KIND_CMD, OP_READ, 7'h01, 8'h10, 8'h00, 5'd2, 1'b0,
                                1'b0, 1'b0, RUN_ACK));
        plan.push_back(plan_row(KIND_TICK, OP_READ, 7'h2a, 8'h55, 8'haa, 5'd21, 1'b1,
                                1'b1, 1'b0, RUN_NONE));

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            send_req(plan[i].req, 1'b1, plan[i].typed, plan[i].busy);
            if (plan[i].run != RUN_NONE) run_to_idle(plan[i].run);
        end

        while (n_items < ITEMS) begin
            pick = $urandom_range(0, 19);
            req  = random_req();
            if (pick == 0) begin
                req.kind = KIND_TICK;
                send_req(req, 1'b0, 1'b0, 1'b0);
            end else if (pick == 1) begin
                req.kind = KIND_CMD;
                req.op   = OP_BAD;
                send_req(req, 1'b0, 1'b0, 1'b0);
            end else begin
                req.kind  = KIND_CMD;
                req.op    = 2'($urandom_range(0, 2));
                // mostly short bursts, now and then a long or saturated one
                req.count = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                        : 5'($urandom_range(0, 4));
                send_req(req, 1'b1, 1'b0, 1'b0);
                run_to_idle(RUN_RANDOM);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && expected_lines.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/i2cra_pkg.sv
hw/rtl/i2cra_front.sv
hw/rtl/i2cra_engine.sv
hw/rtl/i2c_register_access_master_unit.sv
tb/tb_i2c_register_access_master_unit.sv
